[hdl/hps_pkg.sv]
// Shared types and codes of the hashed identifier set.
package hps_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_MOD    = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  typedef struct packed {
    logic present;
    logic reject;
    logic write;
  } way_result_t;

endpackage

[hdl/hps_req_if.sv]
// Request channel: one command and one identifier per transfer.
interface hps_req_if #(
  parameter int PID_BITS = 22
);
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [PID_BITS-1:0] pid;

  modport source (output valid, output command, output pid, input ready);
  modport sink   (input valid, input command, input pid, output ready);
endinterface

[hdl/hps_rsp_if.sv]
// Response channel: presence flag and status per transfer.
interface hps_rsp_if;
  logic valid;
  logic ready;
  logic was_present;
  logic status;

  modport source (output valid, output was_present, output status, input ready);
  modport sink   (input valid, input was_present, input status, output ready);
endinterface

[hdl/hashed_pid_set_core.sv]
// Top level of the hashed identifier set: control, bucket memory and response register.
//
//   channel  direction  transfer carries
//   req_i    in         command, pid
//   rsp_o    out        was_present, status
//
// One item is in flight at a time: the bucket index is registered in rem_q, through quo_q
// and pid_q first when BUCKETS is not a power of two; then the bucket word is read into the
// memory's output register, and its write-back and the response register are loaded together.
// After reset a clearing pass writes every bucket word to empty, one a cycle; no request is
// taken during that pass. A waiting response does not block the next request; only the
// write-back of the following item waits until the output is free.
module hashed_pid_set_core #(
  parameter int BUCKETS  = 4096,
  parameter int WAYS     = 4,
  parameter int PID_BITS = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hps_req_if.sink    req_i,
  hps_rsp_if.source  rsp_o
);
  import hps_pkg::*;

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WORD_W = WAYS * (PID_BITS + 1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    clr_addr_q;
  cmd_e                cmd_q;
  logic [PID_BITS-1:0] pid_q;
  logic [IDX_W-1:0]    bucket_q;
  logic                rsp_valid_q;
  logic                rsp_valid_d;
  logic                was_present_q;
  logic                status_q;

  logic                accept;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_bucket;
  logic                can_finish;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   new_word;
  way_result_t         way_res;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  // Requests are only taken while no item is in flight and the table is usable.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // The write-back may only happen once the response register can take the result.
  assign can_finish  = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_o.ready);

  hps_bucket_mod #(
    .BUCKETS  (BUCKETS),
    .PID_BITS (PID_BITS),
    .IDX_W    (IDX_W)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .pid_i    (req_i.pid),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  // During the clearing pass every bucket word is written to zero, all ways invalid.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = can_finish && way_res.write;
      ram_waddr = bucket_q;
      ram_wdata = new_word;
    end
  end

  hps_bucket_ram #(
    .DEPTH  (BUCKETS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (mod_done),
    .raddr_i (mod_bucket),
    .rdata_o (rd_word)
  );

  // The read data stays in the memory's output register until the next read,
  // so a stalled write-back still sees the word it was computed from.
  hps_way_update #(
    .WAYS     (WAYS),
    .PID_BITS (PID_BITS)
  ) u_ways (
    .cmd_i    (cmd_q),
    .pid_i    (pid_q),
    .word_i   (rd_word),
    .word_o   (new_word),
    .result_o (way_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == IDX_W'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (can_finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (can_finish) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + IDX_W'(1);
      end
    end
  end

  // Unknown command codes fall through the update logic as a look-up.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(req_i.command);
      pid_q <= req_i.pid;
    end
    if (mod_done) begin
      bucket_q <= mod_bucket;
    end
    if (can_finish) begin
      was_present_q <= way_res.present;
      status_q      <= way_res.reject;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.was_present = was_present_q;
  assign rsp_o.status      = status_q;

`ifndef SYNTHESIS
  a_done_in_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_MOD))
    else $error("bucket index finished outside the index state");

  a_present_xor_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.was_present && rsp_o.status))
    else $error("response both present and rejected");

  a_reject_insert_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (can_finish && way_res.reject) |-> (cmd_q == CMD_INSERT))
    else $error("rejection for a command other than insert");

  a_finish_gives_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    can_finish |=> rsp_o.valid)
    else $error("finished item produced no response");

  a_no_write_while_rsp_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPDATE) && rsp_valid_q && !rsp_o.ready) |-> !ram_we)
    else $error("bucket written back while the response register is full");
`endif

endmodule

[hdl/hps_bucket_mod.sv]
// Bucket index unit: identifier modulo the bucket count.
module hps_bucket_mod #(
  parameter int BUCKETS  = 4096,
  parameter int PID_BITS = 22,
  parameter int IDX_W    = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PID_BITS-1:0] pid_i,
  output logic                done_o,
  output logic [IDX_W-1:0]    bucket_o
);

  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic             done_q;
  logic [IDX_W-1:0] rem_q;

  assign done_o   = done_q;
  assign bucket_o = rem_q;

  if (IS_POW2) begin : g_mask
    localparam int EXT_W = PID_BITS + IDX_W;
    logic [EXT_W-1:0] pid_ext;

    // Reducing by a power of two keeps the low bits only.
    assign pid_ext = EXT_W'(pid_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= (BUCKETS > 1) ? pid_ext[IDX_W-1:0] : '0;
      end
    end
  end else begin : g_recip
    // The quotient is exact for every identifier when the reciprocal is rounded up
    // and the shift covers the identifier and index widths.
    localparam int SHIFT = PID_BITS + IDX_W;
    localparam int PRD_W = SHIFT + PID_BITS + 1;
    localparam int DIF_W = PID_BITS + IDX_W;
    localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

    logic [PRD_W-1:0]    prod;
    logic [DIF_W-1:0]    diff;
    logic [PID_BITS:0]   quo_q;
    logic [PID_BITS-1:0] pid_q;
    logic                stage_q;

    // First step: quotient by reciprocal multiplication. Second: remainder by
    // subtracting the quotient times the bucket count.
    assign prod = PRD_W'(pid_i) * PRD_W'(RECIP[PID_BITS:0]);
    assign diff = DIF_W'(pid_q) - DIF_W'(quo_q) * DIF_W'(BUCKETS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= start_i;
        done_q  <= stage_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        pid_q <= pid_i;
        quo_q <= prod[PRD_W-1:SHIFT];
      end
      if (stage_q) begin
        rem_q <= diff[IDX_W-1:0];
      end
    end
  end

endmodule

[hdl/hps_bucket_ram.sv]
// Single-port-write, registered-read memory holding one word per bucket.
module hps_bucket_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 92,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/hps_way_update.sv]
// Parallel way compare and modified bucket word for one command.
module hps_way_update #(
  parameter int WAYS     = 4,
  parameter int PID_BITS = 22
) (
  input  hps_pkg::cmd_e                    cmd_i,
  input  logic [PID_BITS-1:0]              pid_i,
  input  logic [WAYS*(PID_BITS+1)-1:0]     word_i,
  output logic [WAYS*(PID_BITS+1)-1:0]     word_o,
  output hps_pkg::way_result_t             result_o
);
  import hps_pkg::*;

  localparam int SLOT_W = PID_BITS + 1;

  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] free;
  logic [WAYS-1:0] first_free;
  logic            present;
  logic            full;
  logic            ins;
  logic            rem;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      free[w] = !word_i[w*SLOT_W + PID_BITS];
      hit[w]  = !free[w] && (word_i[w*SLOT_W +: PID_BITS] == pid_i);
    end
  end

  // Lowest free way: isolate the lowest set bit of the free mask.
  assign first_free = free & (~free + WAYS'(1));
  assign present    = |hit;
  assign full       = ~|free;
  assign ins        = (cmd_i == CMD_INSERT);
  assign rem        = (cmd_i == CMD_REMOVE);

  always_comb begin
    word_o = word_i;
    for (int w = 0; w < WAYS; w++) begin
      if (ins && !present && first_free[w]) begin
        word_o[w*SLOT_W +: SLOT_W] = {1'b1, pid_i};
      end
      if (rem && hit[w]) begin
        word_o[w*SLOT_W +: SLOT_W] = '0;
      end
    end
  end

  assign result_o.present = present;
  assign result_o.reject  = ins && !present && full;
  assign result_o.write   = (ins && !present && !full) || (rem && present);

endmodule

[tb/sv/hashed_pid_set_checker.sv]
// Checker for the hashed identifier set: tracks set contents and compares every response.
module hashed_pid_set_checker #(
  parameter int BUCKETS  = 4096,
  parameter int WAYS     = 4,
  parameter int PID_BITS = 22
) (
  input  logic clk_i,
  input  logic rst_ni,
  hps_req_if   req_mon,
  hps_rsp_if   rsp_mon,
  output int   mismatches_o,
  output int   pending_o
);
  import hps_pkg::*;

  typedef struct packed {
    logic was_present;
    logic status;
  } set_reply_t;

  // Shadow copy of the bucket table; the initial block leaves every slot empty.
  logic                slot_used [BUCKETS][WAYS];
  logic [PID_BITS-1:0] slot_pid  [BUCKETS][WAYS];
  set_reply_t          reply_queue [$];

  initial begin
    for (int b = 0; b < BUCKETS; b++) begin
      for (int w = 0; w < WAYS; w++) begin
        slot_used[b][w] = 1'b0;
        slot_pid[b][w]  = '0;
      end
    end
  end

  // Applies one command to the shadow table and returns the response it should give.
  // Any command other than insert or remove leaves the set as it is.
  function automatic set_reply_t apply_command(logic [1:0] cmd, logic [PID_BITS-1:0] id);
    int         bucket;
    int         hit_way;
    int         free_way;
    set_reply_t reply;
    bucket   = int'(id % BUCKETS);
    hit_way  = -1;
    free_way = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (slot_used[bucket][w] && slot_pid[bucket][w] == id) hit_way = w;
      if (!slot_used[bucket][w]) free_way = w;
    end
    reply.was_present = (hit_way >= 0);
    reply.status      = 1'b0;
    if (cmd == CMD_INSERT && hit_way < 0) begin
      if (free_way >= 0) begin
        slot_used[bucket][free_way] = 1'b1;
        slot_pid[bucket][free_way]  = id;
      end else begin
        reply.status = 1'b1;
      end
    end else if (cmd == CMD_REMOVE && hit_way >= 0) begin
      slot_used[bucket][hit_way] = 1'b0;
      slot_pid[bucket][hit_way]  = '0;
    end
    return reply;
  endfunction

  task automatic note_failure(string detail);
    if (mismatches_o < 10) $display("%0t: %s", $time, detail);
    mismatches_o++;
  endtask

  always @(posedge clk_i) begin
    set_reply_t wanted;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        reply_queue.push_back(apply_command(req_mon.command, req_mon.pid));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (reply_queue.size() == 0) begin
          note_failure($sformatf("response with nothing outstanding: was_present %0b status %0b",
                                 rsp_mon.was_present, rsp_mon.status));
        end else begin
          wanted = reply_queue.pop_front();
          if (rsp_mon.was_present !== wanted.was_present) begin
            note_failure($sformatf("was_present mismatch: expected %0b, got %0b",
                                   wanted.was_present, rsp_mon.was_present));
          end
          if (rsp_mon.status !== wanted.status) begin
            note_failure($sformatf("status mismatch: expected %0b, got %0b",
                                   wanted.status, rsp_mon.status));
          end
        end
      end
    end
    pending_o <= reply_queue.size();
  end

endmodule

[tb/sv/hashed_pid_set_core_tb.sv]
// Testbench top for the hashed identifier set: clock, reset, stimulus and verdict.
module hashed_pid_set_core_tb;
  import hps_pkg::*;

  localparam int BUCKETS     = 4096;
  localparam int WAYS        = 4;
  localparam int PID_BITS    = 22;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int UPPER_BITS  = PID_BITS - BUCKET_BITS;

  // The command field is two bits wide, so the one spare code is driven as well.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PERCENT = 15;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 10;
  // Time limit of the whole run, in simulation time units: it covers the clearing pass and
  // every item with a wide margin.
  localparam int RUN_LIMIT    = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  hps_req_if #(.PID_BITS(PID_BITS)) req_if ();
  hps_rsp_if                        rsp_if ();

  int mismatches;
  int pending;

  // While steady is set neither side idles. A raised hold_wanted asks the response
  // side for one long stall, which it counts out itself in hold_left.
  logic steady      = 1'b0;
  logic hold_wanted = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;

  // Identifiers for the bulk of the random part are built from a few buckets and a few
  // upper parts, so that buckets fill up, inserts get rejected and removals hit.
  logic [BUCKET_BITS-1:0] pool_bucket [3];
  logic [UPPER_BITS-1:0]  pool_upper  [6];

  hashed_pid_set_core #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .PID_BITS(PID_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  hashed_pid_set_checker #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .PID_BITS(PID_BITS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Response side: random stalls, none during the steady stretch, and one long hold-off
  // on request. During the hold-off the block keeps taking requests until its output
  // register and write-back are both occupied, at which point it must stall its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      hold_done    <= 1'b1;
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  function automatic logic [PID_BITS-1:0] pid_of(int upper, int bucket);
    return {UPPER_BITS'(upper), BUCKET_BITS'(bucket)};
  endfunction

  function automatic logic [1:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return CMD_INSERT;
    if (roll < 65) return CMD_LOOKUP;
    if (roll < 95) return CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is left high,
  // so that the next call either keeps it high or lowers it for an idle gap, but never
  // does both in one step.
  task automatic send_request(logic [1:0] cmd, logic [PID_BITS-1:0] id);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.pid     <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int waited;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.command = CMD_LOOKUP;
    req_if.pid     = '0;

    pool_bucket[0] = '0;
    pool_bucket[1] = '1;
    pool_bucket[2] = BUCKET_BITS'($urandom());
    pool_upper[0]  = '0;
    pool_upper[1]  = '1;
    for (int i = 2; i < 6; i++) pool_upper[i] = UPPER_BITS'($urandom());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block runs its clearing pass first; the first transfer simply
    // waits for ready to come up.
    send_request(CMD_LOOKUP, '0);               // lookup in an empty set
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '0);               // insert of an identifier already held
    send_request(CMD_LOOKUP, '0);
    send_request(CMD_INSERT, '1);               // largest identifier, last bucket
    // Fill all ways of one bucket, then push one more into it.
    for (int k = 0; k < WAYS; k++) send_request(CMD_INSERT, pid_of(k, 5));
    send_request(CMD_INSERT, pid_of(WAYS, 5));  // bucket full: rejected
    send_request(CMD_LOOKUP, pid_of(WAYS, 5));  // the rejected one is absent
    send_request(CMD_REMOVE, pid_of(1, 5));     // frees way 1
    send_request(CMD_REMOVE, pid_of(1, 5));     // removal of an absent identifier
    send_request(CMD_INSERT, pid_of(WAYS, 5));  // lands in the lowest free way
    send_request(CMD_LOOKUP, pid_of(WAYS, 5));
    send_request(CMD_LOOKUP, pid_of(1, 5));
    send_request(CMD_UNUSED, '0);               // spare code acts as a lookup
    send_request(CMD_UNUSED, pid_of(9, 5));
    send_request(CMD_REMOVE, '0);
    send_request(CMD_LOOKUP, '0);
    send_request(CMD_REMOVE, '1);
    send_request(CMD_LOOKUP, '1);

    // Random part: mostly pooled identifiers with weighted commands, the rest fully
    // random identifiers and commands. Items 200 to 299 run with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_wanted = 1'b1;
      if (n == 200) steady = 1'b1;
      if (n == 300) steady = 1'b0;
      if ($urandom_range(0, 99) < 85) begin
        send_request(pick_command(),
                     {pool_upper[$urandom_range(0, 5)], pool_bucket[$urandom_range(0, 2)]});
      end else begin
        send_request(2'($urandom_range(0, 3)), PID_BITS'($urandom()));
      end
    end
    req_if.valid <= 1'b0;

    // Let the checker see the last transfer, wait for every response, then watch a
    // little longer for anything that should not come.
    @(posedge clk_i);
    for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
